// File: rtl/lkd_pkg.sv
// Shared types and constants of the ladder keypad debouncer.
package lkd_pkg;

   localparam int unsigned ADC_W     = 12;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned DEB_W     = 16;
   localparam int unsigned CSR_DAT_W = 48;

   localparam int unsigned LADDER_A_KEYS = 4;
   localparam int unsigned LADDER_B_KEYS = 2;
   localparam int unsigned LVL_A_W       = ADC_W * LADDER_A_KEYS;
   localparam int unsigned LVL_B_W       = ADC_W * LADDER_B_KEYS;

   typedef logic [2:0]        key_type;
   typedef logic [2:0]        csr_idx_type;
   typedef logic [ADC_W-1:0]  adc_type;
   typedef logic [TIME_W-1:0] time_type;

   localparam key_type KEY_NONE  = 3'd0;
   localparam key_type KEY_BACK  = 3'd1;
   localparam key_type KEY_UP    = 3'd5;
   localparam key_type KEY_POWER = 3'd7;

   localparam csr_idx_type CSR_LADDER_A  = 3'd0;
   localparam csr_idx_type CSR_LADDER_B  = 3'd1;
   localparam csr_idx_type CSR_TOLERANCE = 3'd2;
   localparam csr_idx_type CSR_IDLE      = 3'd3;
   localparam csr_idx_type CSR_DEBOUNCE  = 3'd4;
   localparam csr_idx_type CSR_HOLD      = 3'd5;

   localparam logic [LVL_A_W-1:0] LADDER_A_RST  = 48'd230831816078;
   localparam logic [LVL_B_W-1:0] LADDER_B_RST  = 24'd14493;
   localparam adc_type            TOLERANCE_RST = 12'd300;
   localparam adc_type            IDLE_RST      = 12'd3900;
   localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 16'd40;
   localparam time_type           HOLD_RST      = 32'd1000;

endpackage

// File: rtl/lkd_req_if.sv
// Sample channel: power pin, two ladder readings and a timestamp.
interface lkd_req_if
   import lkd_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     power_pin;
   adc_type  adc_a;
   adc_type  adc_b;
   time_type time_ms;

   modport source (output valid, power_pin, adc_a, adc_b, time_ms, input ready);
   modport sink   (input valid, power_pin, adc_a, adc_b, time_ms, output ready);
endinterface

// File: rtl/lkd_rsp_if.sv
// Result channel: key event and power hold flag.
interface lkd_rsp_if
   import lkd_pkg::*;
();
   logic    valid;
   logic    ready;
   logic    event_fires;
   key_type event_key;
   logic    power_held;

   modport source (output valid, event_fires, event_key, power_held, input ready);
   modport sink   (input valid, event_fires, event_key, power_held, output ready);
endinterface

// File: rtl/lkd_csr_if.sv
// Configuration write channel: register index and write data.
interface lkd_csr_if
   import lkd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   csr_idx_type          index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ladder_keypad_debouncer.sv
// Resistor ladder keypad decoder with debounce and power hold detection.
//
// Usage:
//   req_if  carries one sample per transfer: power pin (active low), two 12-bit
//           ladder readings and a free-running millisecond timestamp.
//   rsp_if  returns exactly one result per sample: event flag, new stable key
//           (0 on release) and the power held flag.
//   csr_if  writes the six setup registers (ladder levels, tolerance, idle
//           level, debounce time, hold time); always ready, write while idle.
// Timing:
//   A sample sits one cycle in the input register, where classification, the
//   debounce timer compare and the state update happen, and lands in the
//   result register, which drives rsp valid. Throughput is one sample per
//   cycle while the receiver does not stall; the key state is updated in the
//   same cycle the result is registered, so consecutive samples chain.
// Reset (synchronous, active high): setup registers return to their defaults,
//   stable and candidate key go to none, timers clear, both stages empty.
// Stall: while rsp_if.ready is low the result holds; one more sample waits in
//   the input register, then req_if.ready drops until the result moves.
module ladder_keypad_debouncer
   import lkd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lkd_req_if.sink   req_if,
   lkd_rsp_if.source rsp_if,
   lkd_csr_if.sink   csr_if
);

   // setup registers
   logic [LVL_A_W-1:0] lvl_a_ff;
   logic [LVL_B_W-1:0] lvl_b_ff;
   adc_type            tol_ff;
   adc_type            idle_ff;
   logic [DEB_W-1:0]   deb_ff;
   time_type           hold_ff;

   // input stage
   logic     s1_vld_ff;
   logic     s1_pin_ff;
   adc_type  s1_adc_a_ff;
   adc_type  s1_adc_b_ff;
   time_type s1_time_ff;

   // key state
   key_type  stable_ff,    stable_in;
   key_type  cand_ff,      cand_in;
   time_type cand_start_ff, cand_start_in;
   time_type pwr_down_ff,  pwr_down_in;

   // result stage
   logic    rsp_vld_ff;
   logic    rsp_fires_ff, rsp_fires_in;
   key_type rsp_key_ff,   rsp_key_in;
   logic    rsp_held_ff,  rsp_held_in;

   logic     advance;
   logic     a_idle, b_idle;
   key_type  a_key,  b_key, now_key;
   adc_type  diff_a [LADDER_A_KEYS];
   adc_type  diff_b [LADDER_B_KEYS];
   time_type cand_age, pwr_age;

   // move the sample into the result stage when that stage is free or drains
   assign advance      = s1_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !s1_vld_ff || advance;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid       = rsp_vld_ff;
   assign rsp_if.event_fires = rsp_fires_ff;
   assign rsp_if.event_key   = rsp_key_ff;
   assign rsp_if.power_held  = rsp_held_ff;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_a_ff <= LADDER_A_RST;
         lvl_b_ff <= LADDER_B_RST;
         tol_ff   <= TOLERANCE_RST;
         idle_ff  <= IDLE_RST;
         deb_ff   <= DEBOUNCE_RST;
         hold_ff  <= HOLD_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_LADDER_A:  lvl_a_ff <= csr_if.data[LVL_A_W-1:0];
            CSR_LADDER_B:  lvl_b_ff <= csr_if.data[LVL_B_W-1:0];
            CSR_TOLERANCE: tol_ff   <= csr_if.data[ADC_W-1:0];
            CSR_IDLE:      idle_ff  <= csr_if.data[ADC_W-1:0];
            CSR_DEBOUNCE:  deb_ff   <= csr_if.data[DEB_W-1:0];
            CSR_HOLD:      hold_ff  <= csr_if.data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_pin_ff   <= req_if.power_pin;
         s1_adc_a_ff <= req_if.adc_a;
         s1_adc_b_ff <= req_if.adc_b;
         s1_time_ff  <= req_if.time_ms;
      end
   end

   // classify: one absolute difference and compare per ladder level,
   // lowest level wins, so scan from the top down
   always_comb begin
      a_idle = s1_adc_a_ff > idle_ff;
      b_idle = s1_adc_b_ff > idle_ff;
      a_key  = KEY_NONE;
      b_key  = KEY_NONE;
      for (int i = LADDER_A_KEYS - 1; i >= 0; i--) begin
         diff_a[i] = (s1_adc_a_ff > lvl_a_ff[i*ADC_W +: ADC_W])
                   ? s1_adc_a_ff - lvl_a_ff[i*ADC_W +: ADC_W]
                   : lvl_a_ff[i*ADC_W +: ADC_W] - s1_adc_a_ff;
         if (!a_idle && diff_a[i] < tol_ff) begin
            a_key = KEY_BACK + key_type'(i);
         end
      end
      for (int i = LADDER_B_KEYS - 1; i >= 0; i--) begin
         diff_b[i] = (s1_adc_b_ff > lvl_b_ff[i*ADC_W +: ADC_W])
                   ? s1_adc_b_ff - lvl_b_ff[i*ADC_W +: ADC_W]
                   : lvl_b_ff[i*ADC_W +: ADC_W] - s1_adc_b_ff;
         if (!b_idle && diff_b[i] < tol_ff) begin
            b_key = KEY_UP + key_type'(i);
         end
      end
      priority if (!s1_pin_ff) begin
         now_key = KEY_POWER;
      end else if (a_key != KEY_NONE) begin
         now_key = a_key;
      end else begin
         now_key = b_key;
      end
   end

   // debounce and power hold
   always_comb begin
      cand_in       = cand_ff;
      cand_start_in = cand_start_ff;
      stable_in     = stable_ff;
      pwr_down_in   = pwr_down_ff;
      rsp_fires_in  = 1'b0;
      rsp_key_in    = KEY_NONE;
      // a new candidate restarts its timer at this sample
      if (now_key != cand_ff) begin
         cand_in       = now_key;
         cand_start_in = s1_time_ff;
      end
      cand_age = s1_time_ff - cand_start_in;
      if (cand_age >= time_type'(deb_ff) && cand_in != stable_ff) begin
         stable_in    = cand_in;
         rsp_fires_in = 1'b1;
         rsp_key_in   = cand_in;
         // record press time; clear it only on release
         if (cand_in == KEY_POWER) begin
            pwr_down_in = s1_time_ff;
         end
         if (cand_in == KEY_NONE) begin
            pwr_down_in = '0;
         end
      end
      pwr_age     = s1_time_ff - pwr_down_in;
      rsp_held_in = (stable_in == KEY_POWER) && (pwr_down_in != '0) && (pwr_age >= hold_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff     <= KEY_NONE;
         cand_ff       <= KEY_NONE;
         cand_start_ff <= '0;
         pwr_down_ff   <= '0;
      end else if (advance) begin
         stable_ff     <= stable_in;
         cand_ff       <= cand_in;
         cand_start_ff <= cand_start_in;
         pwr_down_ff   <= pwr_down_in;
      end
   end

   // result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_fires_ff <= rsp_fires_in;
         rsp_key_ff   <= rsp_key_in;
         rsp_held_ff  <= rsp_held_in;
      end
   end

endmodule
